// ===== design/ogoe_pkg.sv =====
// ----------------------------------------------------------------------------
// ogoe_pkg
// Shared types and constants for the occupancy grid obstacle extractor.
// ----------------------------------------------------------------------------
package ogoe_pkg;

  localparam int MAX_GRID_SIDE_DEF = 1024;
  localparam int IDX_W             = 10;
  localparam int COORD_W           = 32;
  localparam int SIZE_W            = 31;
  localparam int THR_W             = 9;
  localparam int VAL_W             = 8;
  localparam int CFG_IDX_W         = 3;
  localparam int QUEUE_DEPTH       = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROBOT_X   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ROBOT_Y   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_USE_SEG   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CUTOFF    = 3'd7;

  localparam logic [SIZE_W-1:0]  CELL_SIZE_RESET = 31'd65536;
  localparam logic [THR_W-1:0]   THRESHOLD_RESET = 9'd50;
  // origin resets to zero, so the first center is half the reset cell size
  localparam logic [COORD_W-1:0] CENTER_RESET =
    COORD_W'({1'b0, CELL_SIZE_RESET[SIZE_W-1:1]});

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] robot_x;
    logic signed [COORD_W-1:0] robot_y;
    logic [SIZE_W-1:0]         cell_size;
    logic signed [THR_W-1:0]   threshold;
    logic                      use_seg;
    logic [SIZE_W-1:0]         cutoff;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]          col;
    logic [IDX_W-1:0]          row;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } cell_rec_t;

endpackage

// ===== design/ogoe_front.sv =====
// ----------------------------------------------------------------------------
// ogoe_front
// Scan tracking and cost test; pushes candidate cells into the queue.
// ----------------------------------------------------------------------------
module ogoe_front import ogoe_pkg::*; #(
  parameter int MAX_GRID_SIDE = MAX_GRID_SIDE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             accept,
  input  logic [VAL_W-1:0] occupancy_value,
  input  logic [VAL_W-1:0] segmentation_value,
  input  logic             first_cell,
  input  logic             column_end,
  output logic             push,
  output cell_rec_t        push_rec
);

  localparam int CW = (MAX_GRID_SIDE > 1) ? $clog2(MAX_GRID_SIDE) : 1;

  logic [CW-1:0]      col_cnt, row_cnt;
  logic [COORD_W-1:0] cx_run, cy_run;

  logic [CW-1:0]      col_e, row_e;
  logic [COORD_W-1:0] cx_e, cy_e, fcx, fcy, half;
  logic [CW:0]        col_inc, row_inc;
  logic [VAL_W+1:0]   cost, thr_ext;
  logic [IDX_W+CW-1:0] col_wide, row_wide;

  assign half = COORD_W'({1'b0, cfg.cell_size[SIZE_W-1:1]});
  assign fcx  = cfg.origin_x + half;
  assign fcy  = cfg.origin_y + half;

  always_comb begin
    col_e = first_cell ? '0  : col_cnt;
    row_e = first_cell ? '0  : row_cnt;
    cx_e  = first_cell ? fcx : cx_run;
    cy_e  = first_cell ? fcy : cy_run;
  end

  assign col_inc = {1'b0, col_e} + (CW+1)'(1);
  assign row_inc = {1'b0, row_e} + (CW+1)'(1);

  // cost fits in 10 bits signed
  always_comb begin
    cost = {{2{occupancy_value[VAL_W-1]}}, occupancy_value};
    if (cfg.use_seg) begin
      cost = cost + {{2{segmentation_value[VAL_W-1]}}, segmentation_value};
    end
  end
  assign thr_ext = {{(VAL_W+2-THR_W){cfg.threshold[THR_W-1]}}, cfg.threshold};

  assign col_wide = (IDX_W+CW)'(col_e);
  assign row_wide = (IDX_W+CW)'(row_e);

  assign push = accept && ($signed(cost) > $signed(thr_ext));
  always_comb begin
    push_rec.col = col_wide[IDX_W-1:0];
    push_rec.row = row_wide[IDX_W-1:0];
    push_rec.cx  = cx_e;
    push_rec.cy  = cy_e;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
      cx_run  <= CENTER_RESET;
      cy_run  <= CENTER_RESET;
    end else if (accept) begin
      if (column_end) begin
        row_cnt <= '0;
        cy_run  <= fcy;
        if (col_inc == (CW+1)'(MAX_GRID_SIDE)) begin
          col_cnt <= '0;
          cx_run  <= fcx;
        end else begin
          col_cnt <= col_inc[CW-1:0];
          cx_run  <= cx_e + COORD_W'(cfg.cell_size);
        end
      end else begin
        col_cnt <= col_e;
        cx_run  <= cx_e;
        if (row_inc == (CW+1)'(MAX_GRID_SIDE)) begin
          row_cnt <= '0;
          cy_run  <= fcy;
        end else begin
          row_cnt <= row_inc[CW-1:0];
          cy_run  <= cy_e + COORD_W'(cfg.cell_size);
        end
      end
    end
  end

endmodule

// ===== design/ogoe_queue.sv =====
// ----------------------------------------------------------------------------
// ogoe_queue
// Short register queue of candidate cells between front and back.
// ----------------------------------------------------------------------------
module ogoe_queue import ogoe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cell_rec_t push_rec,
  output logic      full,
  output logic      q_valid,
  input  logic      pop,
  output cell_rec_t q_rec
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  cell_rec_t     slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [PW:0]   count;

  assign full    = (count == (PW+1)'(QUEUE_DEPTH));
  assign q_valid = (count != '0);
  assign q_rec   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + (PW+1)'(1);
      end else if (pop && !push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

endmodule

// ===== design/ogoe_back.sv =====
// ----------------------------------------------------------------------------
// ogoe_back
// Circle test pipeline: axis distances, squares, compare, output register.
// ----------------------------------------------------------------------------
module ogoe_back import ogoe_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      q_valid,
  input  cell_rec_t q_rec,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output cell_rec_t out_rec
);

  localparam int MW = COORD_W - 1;
  localparam int SW = 2 * MW;

  logic          adv;
  logic [SW-1:0] cut_sq;

  logic            v1, far1;
  cell_rec_t       rec1;
  logic [MW-1:0]   mx1, my1;

  logic            v2, far2;
  cell_rec_t       rec2;
  logic [SW-1:0]   sqx2, sqy2;

  logic [COORD_W:0] dx, dy, ax, ay;
  logic [SW:0]      dist_sq;
  logic             hit;

  assign adv = !out_valid || out_ready;
  assign pop = q_valid && adv;

  assign dx = {cfg.robot_x[COORD_W-1], cfg.robot_x} - {q_rec.cx[COORD_W-1], q_rec.cx};
  assign dy = {cfg.robot_y[COORD_W-1], cfg.robot_y} - {q_rec.cy[COORD_W-1], q_rec.cy};
  assign ax = dx[COORD_W] ? -dx : dx;
  assign ay = dy[COORD_W] ? -dy : dy;

  assign dist_sq = {1'b0, sqx2} + {1'b0, sqy2};
  assign hit     = v2 && !far2 && (dist_sq < {1'b0, cut_sq});

  // the user changes cutoff only while idle; the block does not enforce it
  always_ff @(posedge clk) begin
    cut_sq <= {{MW{1'b0}}, cfg.cutoff} * {{MW{1'b0}}, cfg.cutoff};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rec1 <= q_rec;
      far1 <= ax[COORD_W] | ax[COORD_W-1] | ay[COORD_W] | ay[COORD_W-1];
      mx1  <= ax[MW-1:0];
      my1  <= ay[MW-1:0];
      rec2 <= rec1;
      far2 <= far1;
      sqx2 <= {{MW{1'b0}}, mx1} * {{MW{1'b0}}, mx1};
      sqy2 <= {{MW{1'b0}}, my1} * {{MW{1'b0}}, my1};
      out_rec <= rec2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= q_valid;
      v2        <= v1;
      out_valid <= hit;
    end
  end

endmodule

// ===== design/occupancy_grid_obstacle_extract.sv =====
// ----------------------------------------------------------------------------
// occupancy_grid_obstacle_extract
// Streams grid cells and reports obstacle cells inside the cutoff circle.
// ----------------------------------------------------------------------------
// channel  direction  handshake              payload
// in       sink       in_valid / in_ready    occupancy, segmentation, flags
// out      source     out_valid / out_ready  column, row, center x/y
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one cell per cycle sustained while the queue is not full; the front tracks the scan and a
// passing cell is written into the queue, then goes through the circle test pipeline
// (distance, 31x31 squares, compare) to the output register.
// rst is synchronous and clears counters, queue and pipeline valids.
// a stalled output holds the back pipeline; the four-entry queue absorbs
// candidates until it is full, then in_ready drops. cfg_ready is always high.
// ----------------------------------------------------------------------------
module occupancy_grid_obstacle_extract import ogoe_pkg::*; #(
  parameter int MAX_GRID_SIDE = MAX_GRID_SIDE_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [VAL_W-1:0]   occupancy_value,
  input  logic signed [VAL_W-1:0]   segmentation_value,
  input  logic                      first_cell,
  input  logic                      column_end,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [IDX_W-1:0]          column_index,
  output logic [IDX_W-1:0]          row_index,
  output logic signed [COORD_W-1:0] obstacle_x,
  output logic signed [COORD_W-1:0] obstacle_y,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [COORD_W-1:0]        cfg_data
);

  cfg_t      cfg;
  logic      accept, push, full, q_valid, pop;
  cell_rec_t push_rec, q_rec, out_rec;

  assign cfg_ready = 1'b1;
  assign in_ready  = !full;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x  <= '0;
      cfg.origin_y  <= '0;
      cfg.robot_x   <= '0;
      cfg.robot_y   <= '0;
      cfg.cell_size <= CELL_SIZE_RESET;
      cfg.threshold <= THRESHOLD_RESET;
      cfg.use_seg   <= 1'b0;
      cfg.cutoff    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ORIGIN_X:  cfg.origin_x  <= cfg_data;
        REG_ORIGIN_Y:  cfg.origin_y  <= cfg_data;
        REG_ROBOT_X:   cfg.robot_x   <= cfg_data;
        REG_ROBOT_Y:   cfg.robot_y   <= cfg_data;
        REG_CELL_SIZE: cfg.cell_size <= cfg_data[SIZE_W-1:0];
        REG_THRESHOLD: cfg.threshold <= cfg_data[THR_W-1:0];
        REG_USE_SEG:   cfg.use_seg   <= cfg_data[0];
        REG_CUTOFF:    cfg.cutoff    <= cfg_data[SIZE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  ogoe_front #(
    .MAX_GRID_SIDE(MAX_GRID_SIDE)
  ) u_front (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .accept             (accept),
    .occupancy_value    (occupancy_value),
    .segmentation_value (segmentation_value),
    .first_cell         (first_cell),
    .column_end         (column_end),
    .push               (push),
    .push_rec           (push_rec)
  );

  ogoe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (full),
    .q_valid  (q_valid),
    .pop      (pop),
    .q_rec    (q_rec)
  );

  ogoe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_rec     (q_rec),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_rec   (out_rec)
  );

  assign column_index = out_rec.col;
  assign row_index    = out_rec.row;
  assign obstacle_x   = out_rec.cx;
  assign obstacle_y   = out_rec.cy;

endmodule
